/* sv/gcd_pkg.sv */
// Shared types, constants and fixed-point helpers of the great-circle distance block.
// Used by gcd_isqrt and great_circle_distance; depends on nothing else.
package gcd_pkg;

   localparam int ANGLE_BITS_DEF = 32;
   localparam int ISQRT_NW_DEF = 64;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
   localparam logic [30:0] Q_ONE = 31'h4000_0000;
   localparam logic [22:0] RADIUS_RESET = 23'd6378100;

   typedef struct packed {
      logic advance;
      logic valid;
   } gcd_flow_type;

   typedef struct packed {
      logic [30:0]        x2;
      logic [30:0]        ts;
      logic [30:0]        tc;
      logic signed [32:0] ss;
      logic signed [32:0] cc;
      logic               sw;
   } gcd_tay_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [32:0] dsr;
      logic [28:0] quo;
      logic        sw;
   } gcd_div_type;

   typedef struct packed {
      logic [30:0]        p;
      logic [30:0]        z2;
      logic signed [31:0] sum;
      logic               sw;
   } gcd_atan_type;

   function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] pr;
      pr = 62'(a) * 62'(b) + 62'h2000_0000;
      return pr[60:30];
   endfunction

   function automatic logic [30:0] clamp_unit(input logic signed [32:0] v);
      logic [30:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({2'b00, Q_ONE})) begin
         r = Q_ONE;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

endpackage

/* sv/gcd_isqrt.sv */
// Pipelined floor integer square root, one root bit per register stage.
// Carries a sideband word and a valid flag alongside; uses gcd_pkg.
module gcd_isqrt
   import gcd_pkg::*;
#(
   parameter int NW = ISQRT_NW_DEF,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gcd_flow_type         flow,
   input  logic [NW-1:0]        radicand,
   input  logic [SW-1:0]        side_in,
   output logic [(NW+1)/2-1:0]  root,
   output logic [SW-1:0]        side_out,
   output logic                 valid_out
);

   localparam int RW = (NW + 1) / 2;

   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [SW-1:0]   side_ff [RW];
   logic            v_ff    [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RW:0]     rem_src;
      logic [RW-1:0]   root_src;
      logic [2*RW-1:0] rad_src;
      logic [SW-1:0]   side_src;
      logic            v_src;
      logic [RW+2:0]   rem_sh;
      logic [RW+2:0]   trial;
      logic [RW:0]     rem_in;
      logic [RW-1:0]   root_in;

      if (i == 0) begin : g_head
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = (2*RW)'(radicand);
         assign side_src = side_in;
         assign v_src    = flow.valid;
      end else begin : g_tail
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rad_src  = rad_ff[i-1];
         assign side_src = side_ff[i-1];
         assign v_src    = v_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_src, rad_src[2*RW-1 -: 2]};
         trial  = {1'b0, root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = (RW+1)'(rem_sh - trial);
            root_in = {root_src[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW:0];
            root_in = {root_src[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (flow.advance) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (flow.advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= rad_src << 2;
            side_ff[i] <= side_src;
         end
      end
   end

   assign root      = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];
   assign valid_out = v_ff[RW-1];

endmodule

/* sv/great_circle_distance.sv */
// Throughput one word per cycle while the output buffer is not full or rsp_tready is high.
// The path runs through the four square-root pipelines (31, 31, 31, 32 stages), the 29-stage
// divider and the two 14-stage series pipelines. A two-word output buffer decouples rsp.
// Synchronous reset clears all stage valid flags and the output buffer and loads the
// default radius of 6378100 m. Uses gcd_pkg and gcd_isqrt.
module great_circle_distance
   import gcd_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // first_lat, first_lon, second_lat, second_lon, ANGLE_BITS each, zero padded
   input  logic [((4*ANGLE_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // distance_m [24:0], zero padded
   output logic [31:0]                              rsp_tdata,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [22:0]                              csr_data
);

   localparam int AB  = ANGLE_BITS;
   localparam int UPL = (AB <= 34) ? 34 - AB : 0;
   localparam int DNL = (AB > 34) ? AB - 34 : 0;
   localparam logic [AB-1:0] HALF    = {1'b1, {(AB-1){1'b0}}};
   localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};

   logic        en;
   logic [22:0] radius_ff;

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   // fold angles
   logic [AB-1:0] lat1, lon1, lat2, lon2;
   logic [AB-1:0] ang [3];
   logic [AB-1:0] red [3];
   logic [32:0]   f_in [3];
   logic          fsw_in [3];
   logic [32:0]   f_ff [3];
   logic          fsw_ff [3];
   logic          f_v_ff;

   always_comb begin
      lat1   = req_tdata[AB-1:0];
      lon1   = req_tdata[2*AB-1:AB];
      lat2   = req_tdata[3*AB-1:2*AB];
      lon2   = req_tdata[4*AB-1:3*AB];
      ang[0] = lat2 - lat1;
      ang[1] = lon2 - lon1;
      ang[2] = lat1 + lat2;
      for (int c = 0; c < 3; c++) begin
         red[c]    = {1'b0, ang[c][AB-2:0]};
         fsw_in[c] = ang[c][AB-1];
         if (red[c] > QUARTER) begin
            red[c]    = HALF - red[c];
            fsw_in[c] = !fsw_in[c];
         end
         f_in[c] = 33'((64'(red[c]) << UPL) >> DNL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff   <= f_in;
         fsw_ff <= fsw_in;
      end
   end

   // scale to radians
   logic [64:0] xm [3];
   logic [30:0] x_in [3];
   logic [30:0] x_ff [3];
   logic        xsw_ff [3];
   logic        x_v_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         xm[c]   = 65'(f_ff[c]) * 65'(PI_Q30) + (65'd1 << 33);
         x_in[c] = xm[c][64:34];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff <= 1'b0;
      end else if (en) begin
         x_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         xsw_ff <= fsw_ff;
      end
   end

   // sine and cosine series
   gcd_tay_type tay0_in [3];
   gcd_tay_type tay_ff [15][3];
   logic        tay_v_ff [15];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         tay0_in[c].x2 = qmul(x_ff[c], x_ff[c]);
         tay0_in[c].ts = x_ff[c];
         tay0_in[c].tc = Q_ONE;
         tay0_in[c].ss = $signed({2'b00, x_ff[c]});
         tay0_in[c].cc = $signed({2'b00, Q_ONE});
         tay0_in[c].sw = xsw_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tay_v_ff[0] <= 1'b0;
      end else if (en) begin
         tay_v_ff[0] <= x_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tay_ff[0] <= tay0_in;
      end
   end

   for (genvar j = 0; j < 14; j++) begin : g_tay
      localparam int K   = j / 2 + 1;
      localparam int DS  = (2 * K) * (2 * K + 1);
      localparam int DC  = (2 * K - 1) * (2 * K);
      localparam int SHS = 31 + $clog2(DS);
      localparam int SHC = 31 + $clog2(DC);
      localparam logic [32:0] MS = 33'(((65'd1 << SHS) + 65'(DS - 1)) / 65'(DS));
      localparam logic [32:0] MC = 33'(((65'd1 << SHC) + 65'(DC - 1)) / 65'(DC));
      localparam bit NEG = (K % 2) == 1;

      gcd_tay_type nx [3];
      logic [63:0] ps [3];
      logic [63:0] pc [3];
      logic [30:0] qs [3];
      logic [30:0] qc [3];

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            nx[c] = tay_ff[j][c];
            ps[c] = 64'(nx[c].ts) * 64'(MS);
            pc[c] = 64'(nx[c].tc) * 64'(MC);
            qs[c] = 31'(ps[c] >> SHS);
            qc[c] = 31'(pc[c] >> SHC);
            if ((j % 2) == 0) begin
               nx[c].ts = qmul(tay_ff[j][c].ts, tay_ff[j][c].x2);
               nx[c].tc = qmul(tay_ff[j][c].tc, tay_ff[j][c].x2);
            end else begin
               nx[c].ts = qs[c];
               nx[c].tc = qc[c];
               if (NEG) begin
                  nx[c].ss = tay_ff[j][c].ss - $signed({2'b00, qs[c]});
                  nx[c].cc = tay_ff[j][c].cc - $signed({2'b00, qc[c]});
               end else begin
                  nx[c].ss = tay_ff[j][c].ss + $signed({2'b00, qs[c]});
                  nx[c].cc = tay_ff[j][c].cc + $signed({2'b00, qc[c]});
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tay_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            tay_v_ff[j+1] <= tay_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tay_ff[j+1] <= nx;
         end
      end
   end

   // clamp and unfold
   logic [30:0] sca [3];
   logic [30:0] scb [3];
   logic [30:0] sn_in [3];
   logic [30:0] cs_in [3];
   logic [30:0] sn_ff [3];
   logic [30:0] cs_ff [3];
   logic        sc_v_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sca[c]   = clamp_unit(tay_ff[14][c].ss);
         scb[c]   = clamp_unit(tay_ff[14][c].cc);
         sn_in[c] = tay_ff[14][c].sw ? scb[c] : sca[c];
         cs_in[c] = tay_ff[14][c].sw ? sca[c] : scb[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
      end else if (en) begin
         sc_v_ff <= tay_v_ff[14];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
   end

   // products: order is u*cl, cm*v, cd*cl, sm*v
   logic [30:0] pr_in [4];
   logic [30:0] pr_ff [4];
   logic        pr_v_ff;

   always_comb begin
      pr_in[0] = qmul(sn_ff[0], cs_ff[1]);
      pr_in[1] = qmul(cs_ff[2], sn_ff[1]);
      pr_in[2] = qmul(cs_ff[0], cs_ff[1]);
      pr_in[3] = qmul(sn_ff[2], sn_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else if (en) begin
         pr_v_ff <= sc_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= pr_in;
      end
   end

   // sums of squares, clamped to one
   logic [61:0] shs, sgs;
   logic [60:0] sq_h_in, sq_g_in;
   logic [60:0] sq_h_ff, sq_g_ff;
   logic        sq_v_ff;

   always_comb begin
      shs = 62'(pr_ff[0]) * 62'(pr_ff[0]) + 62'(pr_ff[1]) * 62'(pr_ff[1]);
      sgs = 62'(pr_ff[2]) * 62'(pr_ff[2]) + 62'(pr_ff[3]) * 62'(pr_ff[3]);
      sq_h_in = (shs > (62'd1 << 60)) ? (61'd1 << 60) : shs[60:0];
      sq_g_in = (sgs > (62'd1 << 60)) ? (61'd1 << 60) : sgs[60:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff <= pr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_h_ff <= sq_h_in;
         sq_g_ff <= sq_g_in;
      end
   end

   // roots
   gcd_flow_type flow_a, flow_b, flow_c, flow_d;
   logic [30:0]  rh_a, rg_b, rh_b, r1_c;
   logic [60:0]  sg_a;
   logic [31:0]  r2_d;
   logic         va, vb, vc, vd;

   assign flow_a = '{advance: en, valid: sq_v_ff};

   gcd_isqrt #(.NW(61), .SW(61)) u_root_h (
      .clock(clock), .reset(reset), .flow(flow_a),
      .radicand(sq_h_ff), .side_in(sq_g_ff),
      .root(rh_a), .side_out(sg_a), .valid_out(va)
   );

   assign flow_b = '{advance: en, valid: va};

   gcd_isqrt #(.NW(61), .SW(31)) u_root_g (
      .clock(clock), .reset(reset), .flow(flow_b),
      .radicand(sg_a), .side_in(rh_a),
      .root(rg_b), .side_out(rh_b), .valid_out(vb)
   );

   // order operands
   logic [30:0] od_x_ff, od_y_ff;
   logic        od_sw_ff, od_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         od_v_ff <= 1'b0;
      end else if (en) begin
         od_v_ff <= vb;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         od_sw_ff <= rh_b > rg_b;
         od_x_ff  <= (rh_b > rg_b) ? rh_b : rg_b;
         od_y_ff  <= (rh_b > rg_b) ? rg_b : rh_b;
      end
   end

   // first halving
   logic [61:0] sqa_ff;
   logic [30:0] sqa_x_ff, sqa_y_ff;
   logic        sqa_sw_ff, sqa_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqa_v_ff <= 1'b0;
      end else if (en) begin
         sqa_v_ff <= od_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqa_ff    <= 62'(od_x_ff) * 62'(od_x_ff) + 62'(od_y_ff) * 62'(od_y_ff);
         sqa_x_ff  <= od_x_ff;
         sqa_y_ff  <= od_y_ff;
         sqa_sw_ff <= od_sw_ff;
      end
   end

   logic [62:0] side_c_out;
   assign flow_c = '{advance: en, valid: sqa_v_ff};

   gcd_isqrt #(.NW(62), .SW(63)) u_root_x1 (
      .clock(clock), .reset(reset), .flow(flow_c),
      .radicand(sqa_ff), .side_in({sqa_x_ff, sqa_y_ff, sqa_sw_ff}),
      .root(r1_c), .side_out(side_c_out), .valid_out(vc)
   );

   logic [31:0] x1_ff;
   logic [30:0] x1_y_ff;
   logic        x1_sw_ff, x1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_v_ff <= 1'b0;
      end else if (en) begin
         x1_v_ff <= vc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= 32'(side_c_out[62:32]) + 32'(r1_c);
         x1_y_ff  <= side_c_out[31:1];
         x1_sw_ff <= side_c_out[0];
      end
   end

   // second halving
   logic [63:0] sqb_ff;
   logic [31:0] sqb_x_ff;
   logic [30:0] sqb_y_ff;
   logic        sqb_sw_ff, sqb_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqb_v_ff <= 1'b0;
      end else if (en) begin
         sqb_v_ff <= x1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqb_ff    <= 64'(x1_ff) * 64'(x1_ff) + 64'(x1_y_ff) * 64'(x1_y_ff);
         sqb_x_ff  <= x1_ff;
         sqb_y_ff  <= x1_y_ff;
         sqb_sw_ff <= x1_sw_ff;
      end
   end

   logic [63:0] side_d_out;
   assign flow_d = '{advance: en, valid: sqb_v_ff};

   gcd_isqrt #(.NW(64), .SW(64)) u_root_x2 (
      .clock(clock), .reset(reset), .flow(flow_d),
      .radicand(sqb_ff), .side_in({sqb_x_ff, sqb_y_ff, sqb_sw_ff}),
      .root(r2_d), .side_out(side_d_out), .valid_out(vd)
   );

   // divider: z = (y << 30) / x2
   gcd_div_type div_ff [30];
   logic        div_v_ff [30];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff[0] <= 1'b0;
      end else if (en) begin
         div_v_ff[0] <= vd;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].rem <= 61'(side_d_out[31:1]) << 30;
         div_ff[0].dsr <= 33'(side_d_out[63:32]) + 33'(r2_d);
         div_ff[0].quo <= '0;
         div_ff[0].sw  <= side_d_out[0];
      end
   end

   for (genvar i = 0; i < 29; i++) begin : g_div
      localparam int BIT = 28 - i;
      gcd_div_type dn;
      logic [60:0] dsh;

      always_comb begin
         dn  = div_ff[i];
         dsh = 61'(div_ff[i].dsr) << BIT;
         if (div_ff[i].dsr != '0 && div_ff[i].rem >= dsh) begin
            dn.rem      = div_ff[i].rem - dsh;
            dn.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            div_v_ff[i+1] <= div_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[i+1] <= dn;
         end
      end
   end

   // arctangent series
   gcd_atan_type at0_in;
   gcd_atan_type at_ff [15];
   logic         at_v_ff [15];

   always_comb begin
      at0_in.p   = 31'(div_ff[29].quo);
      at0_in.z2  = qmul(31'(div_ff[29].quo), 31'(div_ff[29].quo));
      at0_in.sum = $signed(32'(div_ff[29].quo));
      at0_in.sw  = div_ff[29].sw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_v_ff[0] <= 1'b0;
      end else if (en) begin
         at_v_ff[0] <= div_v_ff[29];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         at_ff[0] <= at0_in;
      end
   end

   for (genvar j = 0; j < 14; j++) begin : g_atan
      localparam int K  = j / 2 + 1;
      localparam int D  = 2 * K + 1;
      localparam int SH = 31 + $clog2(D);
      localparam logic [32:0] M = 33'(((65'd1 << SH) + 65'(D - 1)) / 65'(D));
      localparam bit NEG = (K % 2) == 1;

      gcd_atan_type an;
      logic [63:0]  pq;
      logic [30:0]  qq;

      always_comb begin
         an = at_ff[j];
         pq = 64'(at_ff[j].p) * 64'(M);
         qq = 31'(pq >> SH);
         if ((j % 2) == 0) begin
            an.p = qmul(at_ff[j].p, at_ff[j].z2);
         end else if (NEG) begin
            an.sum = at_ff[j].sum - $signed({1'b0, qq});
         end else begin
            an.sum = at_ff[j].sum + $signed({1'b0, qq});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            at_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            at_v_ff[j+1] <= at_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            at_ff[j+1] <= an;
         end
      end
   end

   // central angle
   logic [30:0] th_s;
   logic [32:0] th_p4;
   logic [32:0] th_in;
   logic [32:0] th_ff;
   logic        th_v_ff;

   always_comb begin
      th_s  = (at_ff[14].sum < 0) ? '0 : at_ff[14].sum[30:0];
      th_p4 = {th_s, 2'b00};
      if (!at_ff[14].sw) begin
         th_in = th_p4;
      end else if (th_p4 > HALF_PI_Q30) begin
         th_in = '0;
      end else begin
         th_in = HALF_PI_Q30 - th_p4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         th_v_ff <= 1'b0;
      end else if (en) begin
         th_v_ff <= at_v_ff[14];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         th_ff <= th_in;
      end
   end

   // scale by radius, two-word output buffer
   logic [55:0] dm;
   logic [24:0] dist_in;
   logic [24:0] ob0_ff, ob1_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign dm      = 56'(radius_ff) * 56'(th_ff) + (56'd1 << 28);
   assign dist_in = dm[53:29];

   assign en         = (cnt_ff != 2'd2) || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = {7'd0, ob0_ff};
   assign push       = en && th_v_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push && !pop) begin
         cnt_ff <= cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      priority if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            ob0_ff <= dist_in;
         end else begin
            ob0_ff <= ob1_ff;
            ob1_ff <= dist_in;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ob0_ff <= dist_in;
         end else begin
            ob1_ff <= dist_in;
         end
      end else if (pop) begin
         ob0_ff <= ob1_ff;
      end else begin
         ob0_ff <= ob0_ff;
      end
   end

endmodule
